>>> rtl/dpd_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helpers for the debug packet deframer.
// Depends on nothing; every other file refers to it by scoped names.
package dpd_pkg;

    // Fixed field widths
    localparam int BYTE_W    = 8;
    localparam int EVENT_W   = 3;
    localparam int LEN_W     = 9;
    localparam int CFG_W     = 9;
    localparam int OUT_DATA_W = 32;

    // Default build-time ceiling on the payload length and reset of the limit register
    localparam int                PAYLOAD_LIMIT_DEF = 256;
    localparam logic [CFG_W-1:0]  MAX_PAYLOAD_RST   = 9'd256;

    // Framing characters
    localparam logic [BYTE_W-1:0] SOP_CHAR = 8'h24;
    localparam logic [BYTE_W-1:0] EOP_CHAR = 8'h23;
    localparam logic [BYTE_W-1:0] BRK_CHAR = 8'h03;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_CHK1 = 2'd2,
        PH_CHK2 = 2'd3
    } t_phase;

    // Result kinds
    typedef enum logic [EVENT_W-1:0] {
        EV_BYTE     = 3'd0,
        EV_START    = 3'd1,
        EV_GOOD     = 3'd2,
        EV_BAD      = 3'd3,
        EV_OVERFLOW = 3'd4,
        EV_BREAK    = 3'd5
    } t_event;

    // One result item
    typedef struct packed {
        t_event            event_res;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  payload_length;
        logic [BYTE_W-1:0] computed_sum;
    } t_result;

    // Hex digit value; anything else counts as -1 modulo 256.
    function automatic logic [BYTE_W-1:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h61 + 8'd10;
        end else if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h41 + 8'd10;
        end else begin
            v = 8'hFF;
        end
        return v;
    endfunction

endpackage

>>> rtl/dpd_step.sv
`timescale 1ns / 1ps
// Input register, packet parser state and per-byte result logic.
// Depends on dpd_pkg.
module dpd_step #(
    parameter int PAYLOAD_LIMIT = dpd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dpd_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic [dpd_pkg::CFG_W-1:0]    i_max_payload,
    input  logic                         i_res_ready,
    output logic                         o_res_valid,
    output dpd_pkg::t_result             o_res
);

    // The count never passes the clamped limit, which is at most what the register can hold
    localparam int CFG_MAX = (1 << dpd_pkg::CFG_W) - 1;
    localparam int CNT_MAX = (PAYLOAD_LIMIT < CFG_MAX) ? PAYLOAD_LIMIT : CFG_MAX;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int PL_W    = $clog2(PAYLOAD_LIMIT + 1);
    localparam int CMP_W   = (PL_W > dpd_pkg::CFG_W) ? PL_W : dpd_pkg::CFG_W;

    logic                        r_in_valid;
    logic [dpd_pkg::BYTE_W-1:0]  r_in_byte;
    dpd_pkg::t_phase             r_phase, n_phase;
    logic [dpd_pkg::BYTE_W-1:0]  r_sum, n_sum;
    logic [dpd_pkg::BYTE_W-1:0]  r_exp, n_exp;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        advance;
    logic                        in_accept;
    logic [CMP_W-1:0]            lim_cfg;
    logic [CMP_W-1:0]            lim;
    logic                        full;
    logic [dpd_pkg::BYTE_W-1:0]  dig;
    logic                        has_res;
    dpd_pkg::t_result            res;

    // Input register: a held byte is processed when the result side has room
    assign advance    = r_in_valid && i_res_ready;
    assign o_in_ready = !r_in_valid || i_res_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Active payload limit: zero acts as one, clamped to the build-time ceiling
    always_comb begin
        lim_cfg = (i_max_payload == '0) ? CMP_W'(1) : CMP_W'(i_max_payload);
        lim     = (lim_cfg > CMP_W'(PAYLOAD_LIMIT)) ? CMP_W'(PAYLOAD_LIMIT) : lim_cfg;
    end
    assign full = CMP_W'(r_count) >= lim;

    // Value of the held byte as a check digit
    assign dig = dpd_pkg::digit_value(r_in_byte);

    // Next state of the parser
    always_comb begin
        n_phase = r_phase;
        n_sum   = r_sum;
        n_exp   = r_exp;
        n_count = r_count;
        case (r_phase)
            dpd_pkg::PH_IDLE: begin
                if (r_in_byte == dpd_pkg::SOP_CHAR) begin
                    n_sum   = '0;
                    n_count = '0;
                    n_phase = dpd_pkg::PH_DATA;
                end
            end
            dpd_pkg::PH_DATA: begin
                if (r_in_byte == dpd_pkg::SOP_CHAR) begin
                    n_sum   = '0;
                    n_count = '0;
                end else if (full) begin
                    n_phase = dpd_pkg::PH_IDLE;
                end else if (r_in_byte == dpd_pkg::EOP_CHAR) begin
                    n_phase = dpd_pkg::PH_CHK1;
                end else begin
                    n_sum   = r_sum + r_in_byte;
                    n_count = r_count + 1'b1;
                end
            end
            dpd_pkg::PH_CHK1: begin
                n_exp   = {dig[3:0], 4'h0};
                n_phase = dpd_pkg::PH_CHK2;
            end
            dpd_pkg::PH_CHK2: begin
                n_exp   = r_exp + dig;
                n_phase = dpd_pkg::PH_IDLE;
            end
            default: begin
                n_phase = dpd_pkg::PH_IDLE;
            end
        endcase
    end

    // Result for the byte in the input register
    always_comb begin
        has_res            = 1'b0;
        res.event_res      = dpd_pkg::EV_BYTE;
        res.data_byte      = '0;
        res.payload_length = '0;
        res.computed_sum   = '0;
        case (r_phase)
            dpd_pkg::PH_IDLE: begin
                if (r_in_byte == dpd_pkg::SOP_CHAR) begin
                    has_res       = 1'b1;
                    res.event_res = dpd_pkg::EV_START;
                end else if (r_in_byte == dpd_pkg::BRK_CHAR) begin
                    has_res       = 1'b1;
                    res.event_res = dpd_pkg::EV_BREAK;
                end
            end
            dpd_pkg::PH_DATA: begin
                if (r_in_byte == dpd_pkg::SOP_CHAR) begin
                    has_res       = 1'b1;
                    res.event_res = dpd_pkg::EV_START;
                end else if (full) begin
                    has_res       = 1'b1;
                    res.event_res = dpd_pkg::EV_OVERFLOW;
                end else if (r_in_byte != dpd_pkg::EOP_CHAR) begin
                    has_res       = 1'b1;
                    res.data_byte = r_in_byte;
                end
            end
            dpd_pkg::PH_CHK1: begin
                has_res = 1'b0;
            end
            dpd_pkg::PH_CHK2: begin
                has_res            = 1'b1;
                res.event_res      = (r_sum == n_exp) ? dpd_pkg::EV_GOOD : dpd_pkg::EV_BAD;
                res.payload_length = dpd_pkg::LEN_W'(r_count);
                res.computed_sum   = r_sum;
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

    assign o_res_valid = advance && has_res;
    assign o_res       = res;

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dpd_pkg::PH_IDLE;
            r_sum   <= '0;
            r_exp   <= '0;
            r_count <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_exp   <= n_exp;
            r_count <= n_count;
        end
    end

    // The second check digit always closes the packet with a verdict
    a_chk2_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_phase == dpd_pkg::PH_CHK2 |->
            o_res_valid && (o_res.event_res == dpd_pkg::EV_GOOD ||
                            o_res.event_res == dpd_pkg::EV_BAD))
        else $error("check digit phase gave no verdict");

    // The payload count never passes the build-time ceiling
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(PAYLOAD_LIMIT))
        else $error("payload count beyond limit");

    // Every payload byte passed on is counted
    a_byte_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.event_res == dpd_pkg::EV_BYTE |=>
            r_count == $past(r_count) + 1'b1)
        else $error("payload byte not counted");

    // The parser only moves when a byte is processed
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_phase) && $stable(r_count))
        else $error("parser state changed without a byte");

endmodule

>>> rtl/dpd_out_buf.sv
`timescale 1ns / 1ps
// Two-entry result buffer that decouples the parser from output back-pressure.
// Depends on dpd_pkg.
module dpd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_room,
    input  dpd_pkg::t_result i_res,
    output logic             o_valid,
    input  logic             i_ready,
    output dpd_pkg::t_result o_res
);

    dpd_pkg::t_result r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic             pop;

    // Room is judged on the registered fill so no path runs from the output handshake
    assign o_room  = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_slot[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Fill never exceeds the two slots
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer fill out of range");

    // No push into a full buffer
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !i_push)
        else $error("push into full result buffer");

    // Pointers differ exactly when one slot is in use
    a_ptr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr != r_rd_ptr) == (r_cnt == 2'd1))
        else $error("buffer pointers disagree with fill");

endmodule

>>> rtl/debug_packet_deframer_core.sv
`timescale 1ns / 1ps
// Top level of the debug packet deframer: limit register, parser and result buffer.
// Depends on dpd_pkg, dpd_step and dpd_out_buf.

// The deframer takes one received byte per clock cycle and keeps that rate for any
// run of bytes, as long as results are taken as fast as they are produced. A byte
// is held in the input register, the parser logic forms its result, and the result
// is written into the two-entry result buffer, from which it is presented at the
// output; the buffer lets input continue while the output side stalls, until both
// of its entries are full. Bytes that yield no result (the '#' marker, the first
// check digit, idle noise) still need room in the result buffer. The payload limit
// register should only be written while no bytes are in flight.
module debug_packet_deframer_core #(
    parameter int PAYLOAD_LIMIT = dpd_pkg::PAYLOAD_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Received bytes
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] rx_byte
    // Results
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [dpd_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,   // [7:0] data_byte,
                                                              // [16:8] payload_length,
                                                              // [24:17] computed_sum,
                                                              // [31:25] zero
    output logic [dpd_pkg::EVENT_W-1:0]     o_m_axis_tuser,   // [2:0] event_res
    // Payload limit register
    input  logic                            i_cfg_wr_en,
    input  logic [dpd_pkg::CFG_W-1:0]       i_cfg_wr_data
);

    logic [dpd_pkg::CFG_W-1:0] r_max_payload;
    logic                      res_valid;
    logic                      buf_room;
    dpd_pkg::t_result          step_res;
    dpd_pkg::t_result          out_res;

    // Payload limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= dpd_pkg::MAX_PAYLOAD_RST;
        end else if (i_cfg_wr_en) begin
            r_max_payload <= i_cfg_wr_data;
        end
    end

    // Parser
    dpd_step #(
        .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_in_byte     (i_s_axis_tdata),
        .i_max_payload (r_max_payload),
        .i_res_ready   (buf_room),
        .o_res_valid   (res_valid),
        .o_res         (step_res)
    );

    // Result buffer
    dpd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .o_room  (buf_room),
        .i_res   (step_res),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (out_res)
    );

    // Output packing
    assign o_m_axis_tdata = {7'd0, out_res.computed_sum, out_res.payload_length,
                             out_res.data_byte};
    assign o_m_axis_tuser = out_res.event_res;

endmodule
